// ===== rtl/rdc_pkg.sv =====
package rdc_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF  = 32;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 6;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0]  ASCII_NINE  = 6'd57;
    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 4'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = 4'd10;
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 4'd2;

    function automatic logic [DIGIT_W-1:0] sat_radix(input logic [DIGIT_W-1:0] raw);
        logic [DIGIT_W-1:0] res;
        res = raw;
        if (raw < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (raw > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

endpackage

// ===== rtl/rdc_if.sv =====
interface rdc_value_if #(parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value_in;

    modport source (output valid, output value_in, input ready);
    modport sink   (input valid, input value_in, output ready);
endinterface

interface rdc_digit_if;
    logic                        valid;
    logic                        ready;
    logic [rdc_pkg::CHAR_W-1:0]  digit_char;
    logic                        last_digit;
    logic                        negative_error;

    modport source (output valid, output digit_char, output last_digit,
                    output negative_error, input ready);
    modport sink   (input valid, input digit_char, input last_digit,
                    input negative_error, output ready);
endinterface

interface rdc_radix_if;
    logic                        valid;
    logic                        ready;
    logic [rdc_pkg::DIGIT_W-1:0] radix;

    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

// ===== rtl/rdc_ram.sv =====
module rdc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/rdc_divider.sv =====
module rdc_divider #(
    parameter int QW = rdc_pkg::VALUE_WIDTH_DEF - 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [QW-1:0]               i_dividend,
    input  logic [rdc_pkg::DIGIT_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [QW-1:0]               o_quotient,
    output logic [rdc_pkg::DIGIT_W-1:0] o_remainder
);
    import rdc_pkg::*;

    localparam int NW = $clog2(QW + 1);

    logic [QW-1:0]      r_quot;
    logic [DIGIT_W-1:0] r_rem;
    logic [DIGIT_W-1:0] r_div;
    logic [NW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DIGIT_W:0]   trial;
    logic [DIGIT_W:0]   diff;
    logic               ge;

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    always_comb begin
        trial = {r_rem, r_quot[QW-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - NW'(1);
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[QW-2:0], ge};
            r_rem  <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quot;
    assign o_remainder = r_rem;
endmodule

// ===== rtl/radix_digit_converter.sv =====
// Converts a signed integer into ASCII digits in a base from 2 to 10, one
// word per digit, most significant digit first, with last_digit set on the
// final word. Zero gives the single word '0'; a negative value gives one word
// with negative_error and last_digit set and digit_char zero. A radix write
// below 2 or above 10 is clamped into range, and writes are always accepted.
// One shared restoring divider produces one quotient bit per cycle, so each
// digit costs VALUE_WIDTH-1 restoring steps of division, after which the
// divider restarts on the quotient for the next digit. Once the quotient is
// zero, each digit is read back from the digit store, loaded into the output
// register and held there until it is taken, so any output stall holds the
// conversion. The input is not ready until the last word of the current
// conversion has been taken.
// If a value needs more than MAX_DIGITS digits, only the MAX_DIGITS least
// significant ones are emitted.
module radix_digit_converter #(
    parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rdc_value_if.sink   i_value,
    rdc_digit_if.source o_digit,
    rdc_radix_if.sink   i_cfg
);
    import rdc_pkg::*;

    localparam int QW = VALUE_WIDTH - 1;
    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [DIGIT_W-1:0] r_radix, n_radix;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_rd_idx, n_rd_idx;
    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_out_char, n_out_char;
    logic               r_out_last, n_out_last;
    logic               r_out_err, n_out_err;

    logic               div_start;
    logic [QW-1:0]      div_dividend;
    logic               div_done;
    logic [QW-1:0]      div_quot;
    logic [DIGIT_W-1:0] div_rem;
    logic               ram_we;
    logic               ram_re;
    logic [DIGIT_W-1:0] ram_rdata;
    logic [CW-1:0]      cnt_m1;

    rdc_divider #(.QW(QW)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (r_radix),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    rdc_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (div_rem),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_radix      = r_radix;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_out_valid  = r_out_valid;
        n_out_char   = r_out_char;
        n_out_last   = r_out_last;
        n_out_err    = r_out_err;
        div_start    = 1'b0;
        div_dividend = i_value.value_in[QW-1:0];
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        cnt_m1       = '0;

        if (i_cfg.valid) begin
            n_radix = sat_radix(i_cfg.radix);
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_value.valid) begin
                    if (i_value.value_in[VALUE_WIDTH-1]) begin
                        n_out_valid = 1'b1;
                        n_out_char  = '0;
                        n_out_last  = 1'b1;
                        n_out_err   = 1'b1;
                        n_state     = S_OUT;
                    end else begin
                        div_start = 1'b1;
                        n_count   = '0;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (r_count < CW'(MAX_DIGITS)) begin
                        ram_we  = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                    if (div_quot != '0) begin
                        div_start    = 1'b1;
                        div_dividend = div_quot;
                    end else begin
                        cnt_m1   = n_count - CW'(1);
                        n_rd_idx = cnt_m1[AW-1:0];
                        n_state  = S_READ;
                    end
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_out_valid = 1'b1;
                n_out_char  = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, ram_rdata};
                n_out_last  = (r_rd_idx == '0);
                n_out_err   = 1'b0;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (o_digit.ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx - AW'(1);
                        n_state  = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix     <= RADIX_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_radix     <= n_radix;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    assign i_value.ready          = (r_state == S_IDLE);
    assign i_cfg.ready            = 1'b1;
    assign o_digit.valid          = r_out_valid;
    assign o_digit.digit_char     = r_out_char;
    assign o_digit.last_digit     = r_out_last;
    assign o_digit.negative_error = r_out_err;
endmodule

// ===== rtl/rdc_checker.sv =====
module rdc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [rdc_pkg::CHAR_W-1:0] i_digit_char,
    input logic                       i_last_digit,
    input logic                       i_negative_error
);
    import rdc_pkg::*;

    // An error word carries no digit and closes the conversion.
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_negative_error |-> i_last_digit && (i_digit_char == '0))
        else $error("error word must be final with a zero character");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_negative_error |->
            (i_digit_char >= ASCII_ZERO) && (i_digit_char <= ASCII_NINE))
        else $error("digit character outside '0'..'9'");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted again while a conversion is running");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a word is pending");

    a_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_digit_char) && $stable(i_last_digit)
            && $stable(i_negative_error))
        else $error("pending word changed before it was taken");
endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_value.valid),
    .i_in_ready       (i_value.ready),
    .i_out_valid      (o_digit.valid),
    .i_out_ready      (o_digit.ready),
    .i_digit_char     (o_digit.digit_char),
    .i_last_digit     (o_digit.last_digit),
    .i_negative_error (o_digit.negative_error)
);

// ===== tb/sv/radix_digit_converter_test.sv =====
module radix_digit_converter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rdc_pkg::*;

    localparam int CYCLE_LIMIT = 1_200_000;

    typedef struct packed {
        logic [CHAR_W-1:0] ascii;
        logic              last;
        logic              err;
    } t_digit_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rdc_value_if #(.VALUE_WIDTH(VALUE_WIDTH_DEF)) val_if ();
    rdc_digit_if                                  dig_if ();
    rdc_radix_if                                  cfg_if ();

    radix_digit_converter #(
        .VALUE_WIDTH(VALUE_WIDTH_DEF),
        .MAX_DIGITS (MAX_DIGITS_DEF)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_value(val_if),
        .o_digit(dig_if),
        .i_cfg  (cfg_if)
    );

    logic [VALUE_WIDTH_DEF-1:0] value_backlog[$];
    logic [DIGIT_W-1:0]         radix_backlog[$];
    t_digit_word                expected_digits[$];
    logic [DIGIT_W-1:0]         radix_setting;
    logic [DIGIT_W-1:0]         current_base;
    bit                         gap_mode;
    bit                         stall_mode;
    int                         value_gap;
    int                         stall_left;
    int                         error_count;
    int                         cycle_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [DIGIT_W-1:0] clamp_base(input logic [DIGIT_W-1:0] raw);
        if (raw < RADIX_MIN) begin
            return RADIX_MIN;
        end
        if (raw > RADIX_MAX) begin
            return RADIX_MAX;
        end
        return raw;
    endfunction

    function automatic int pick_gap(input bit enabled);
        int roll;
        roll = $urandom_range(0, 15);
        if (!enabled || roll < 9) begin
            return 0;
        end
        if (roll < 14) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 20);
    endfunction

    // Remainders come out least significant first; the words go out most
    // significant first, so the list is drained from its tail.
    function automatic void expand_digits(input logic [VALUE_WIDTH_DEF-1:0] value,
                                          input logic [DIGIT_W-1:0] base);
        logic [VALUE_WIDTH_DEF-1:0] quotient;
        logic [DIGIT_W-1:0]         remainders[$];
        t_digit_word                word;
        if (value[VALUE_WIDTH_DEF-1]) begin
            word.ascii = '0;
            word.last  = 1'b1;
            word.err   = 1'b1;
            expected_digits.push_back(word);
        end else begin
            quotient = value;
            do begin
                if (remainders.size() < MAX_DIGITS_DEF) begin
                    remainders.push_back(DIGIT_W'(quotient % base));
                end
                quotient = quotient / base;
            end while (quotient != 0);
            while (remainders.size() != 0) begin
                word.ascii = ASCII_ZERO + {2'b00, remainders.pop_back()};
                word.last  = (remainders.size() == 0);
                word.err   = 1'b0;
                expected_digits.push_back(word);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            val_if.valid    <= 1'b0;
            val_if.value_in <= '0;
            value_gap       <= 0;
        end else if (!val_if.valid || val_if.ready) begin
            if (value_gap != 0 || value_backlog.size() == 0) begin
                val_if.valid <= 1'b0;
                if (value_gap != 0) begin
                    value_gap <= value_gap - 1;
                end
            end else begin
                val_if.valid    <= 1'b1;
                val_if.value_in <= value_backlog.pop_front();
                value_gap       <= pick_gap(gap_mode);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_if.valid <= 1'b0;
            cfg_if.radix <= '0;
        end else if (!cfg_if.valid || cfg_if.ready) begin
            if (radix_backlog.size() != 0) begin
                cfg_if.valid <= 1'b1;
                cfg_if.radix <= radix_backlog.pop_front();
            end else begin
                cfg_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dig_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left != 0) begin
            dig_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            dig_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                stall_left <= pick_gap(stall_mode);
            end
        end
    end

    always @(posedge i_clk) begin
        t_digit_word want;
        if (!i_rst_n) begin
            radix_setting = RADIX_RESET;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                radix_setting = clamp_base(cfg_if.radix);
            end
            if (val_if.valid && val_if.ready) begin
                expand_digits(val_if.value_in, radix_setting);
            end
            if (dig_if.valid && dig_if.ready) begin
                if (expected_digits.size() == 0) begin
                    $error("word with no expectation: digit_char %0d, last_digit %0d, negative_error %0d",
                           dig_if.digit_char, dig_if.last_digit, dig_if.negative_error);
                    error_count++;
                end else begin
                    want = expected_digits.pop_front();
                    if (dig_if.digit_char !== want.ascii) begin
                        $error("digit_char: expected %0d, got %0d", want.ascii, dig_if.digit_char);
                        error_count++;
                    end
                    if (dig_if.last_digit !== want.last) begin
                        $error("last_digit: expected %0d, got %0d", want.last, dig_if.last_digit);
                        error_count++;
                    end
                    if (dig_if.negative_error !== want.err) begin
                        $error("negative_error: expected %0d, got %0d",
                               want.err, dig_if.negative_error);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("radix_digit_converter_test: done, errors");
            $finish;
        end
    end

    task automatic wait_idle();
        while (value_backlog.size() != 0 || val_if.valid || radix_backlog.size() != 0
               || cfg_if.valid || expected_digits.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);
    endtask

    task automatic set_radix(input logic [DIGIT_W-1:0] raw);
        wait_idle();
        radix_backlog.push_back(raw);
        current_base = clamp_base(raw);
        wait_idle();
    endtask

    // A mix of full-range words (negatives among them), values sitting on
    // digit-count boundaries of the current base, positive words and short ones.
    task automatic run_random_phase(input int count);
        longint unsigned power;
        int              steps;
        logic [31:0]     value;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: value = $urandom;
                4, 5: value = $urandom_range(0, 1000);
                6, 7: begin
                    power = 1;
                    steps = $urandom_range(0, 31);
                    while (steps != 0 && power * current_base < 64'h8000_0000) begin
                        power = power * current_base;
                        steps--;
                    end
                    value = $urandom_range(0, 1) ? 32'(power) : 32'(power - 1);
                end
                8: value = $urandom & 32'h7FFF_FFFF;
                default: value = $urandom_range(0, current_base);
            endcase
            value_backlog.push_back(value);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        current_base    = RADIX_RESET;
        gap_mode        = 1'b1;
        stall_mode      = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        value_backlog = '{32'd0, 32'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                          32'h5555_5555, 32'hAAAA_AAAA, 32'd2, 32'd3};
        set_radix(4'd10);
        value_backlog = '{32'd9, 32'd10, 32'd99, 32'd100, 32'h7FFF_FFFF,
                          32'd1_000_000_000, 32'd0};
        set_radix(4'd0);
        value_backlog = '{32'd1, 32'd1024};
        set_radix(4'd15);
        value_backlog = '{32'd999_999_999};
        set_radix(4'd1);
        value_backlog = '{32'd7};
        set_radix(4'd11);
        value_backlog = '{32'd123_456_789};
        set_radix(4'd3);
        value_backlog = '{32'h7FFF_FFFF, 32'd1_162_261_467};

        for (int phase = 0; phase < 8; phase++) begin
            set_radix(DIGIT_W'($urandom_range(0, 15)));
            gap_mode   = $urandom_range(0, 2) != 0;
            stall_mode = $urandom_range(0, 2) != 0;
            run_random_phase(12);
        end

        wait_idle();
        repeat (200) @(negedge i_clk);
        if (error_count == 0 && expected_digits.size() == 0) begin
            $display("radix_digit_converter_test: done, clean");
        end else begin
            $display("radix_digit_converter_test: done, errors");
        end
        $finish;
    end

endmodule
